// ===== rtl/ddmc_pkg.sv =====
// Shared codes, field widths and result type of the differential drive motion controller.
package ddmc_pkg;

	localparam int MODE_W   = 2;
	localparam int EVENT_W  = 2;
	localparam int PHASE_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// input modes
	localparam logic [MODE_W-1:0] MODE_DRIVE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ROTATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

	// result events
	localparam logic [EVENT_W-1:0] EV_SPEED    = 2'd0;
	localparam logic [EVENT_W-1:0] EV_AT_GOAL  = 2'd1;
	localparam logic [EVENT_W-1:0] EV_OBSTACLE = 2'd2;

	// motion phase
	localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
	localparam logic [PHASE_W-1:0] PH_DRIVE  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_ROTATE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SKEW     = 2'd3;

	localparam logic [5:0] CRUISE_MAX   = 6'd32;
	localparam logic [6:0] SPEED_MAX    = 7'd127;

	typedef struct packed {
		logic signed [7:0]   left;
		logic signed [7:0]   right;
		logic [EVENT_W-1:0]  ev;
	} res_t;

endpackage

// ===== rtl/differential_drive_motion_controller.sv =====
// Top level of the differential drive motion controller: input stage, result sequencer, state.
//
// Each transaction on the input channel is registered, then its results are formed one per
// cycle into the output register while the output is not stalled. A new transaction is taken
// every cycle while each has one result or none and the output is not stalled. A drive command
// emits 2*min(cruise_speed,32) ramp results and stalls the input channel until its last one is
// loaded; a tick that meets an obstacle emits two and stalls it likewise. Output stalls lengthen
// these stalls; the result counter in the input stage ends them. Only the difference of the two
// encoder sums is kept, which is all the speed correction and skew check use. Configuration
// writes are always taken (cfg_ready is high).
module differential_drive_motion_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ddmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ddmc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ddmc_pkg::MODE_W-1:0]       mode,
	input  logic signed [15:0]                target,
	input  logic signed [15:0]                left_count_delta,
	input  logic signed [15:0]                right_count_delta,
	input  logic [23:0]                       travelled,
	input  logic signed [10:0]                front_range,
	input  logic signed [31:0]                heading_total,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [7:0]                 left_speed,
	output logic signed [7:0]                 right_speed,
	output logic [ddmc_pkg::EVENT_W-1:0]      event_res,
	output logic                              last
);
	import ddmc_pkg::*;

	// configuration
	logic [5:0] cruise_q;
	logic [6:0] turn_q;
	logic [9:0] obstacle_q;
	logic [7:0] skew_q;

	// input stage
	logic                valid_s1;
	logic [MODE_W-1:0]   mode_s1;
	logic signed [15:0]  target_s1;
	logic signed [16:0]  cdiff_s1;
	logic [23:0]         trav_s1;
	logic signed [10:0]  front_s1;
	logic signed [31:0]  head_s1;

	// motion state
	logic [PHASE_W-1:0]  phase_q;
	logic [31:0]         diff_q;
	logic signed [15:0]  goal_q;
	logic signed [31:0]  prior_q;
	logic [31:0]         turned_q;
	logic [5:0]          k_q;

	// output register
	logic                out_valid_q;
	res_t                res_q;
	logic                last_q;

	logic        in_acc, out_load, emit, done, is_last;
	logic [6:0]  n_res;
	res_t        res;
	logic [5:0]  cruise_eff;

	logic [31:0]        new_diff, neg_diff;
	logic               skew_bad;
	logic signed [8:0]  d9;
	logic signed [10:0] d3;
	logic signed [9:0]  half_d3;
	logic signed [10:0] sp_raw;
	logic [6:0]         sp;
	logic               goal_met, blocked;

	logic signed [32:0] hdiff;
	logic [31:0]        habs;
	logic [32:0]        tsum;
	logic [31:0]        tsat;
	logic [15:0]        gabs;
	logic               rot_done;
	logic [6:0]         k_inc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cruise_q   <= 6'd30;
			turn_q     <= 7'd10;
			obstacle_q <= 10'd50;
			skew_q     <= 8'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CRUISE:   cruise_q   <= cfg_data[5:0];
				REG_TURN:     turn_q     <= cfg_data[6:0];
				REG_OBSTACLE: obstacle_q <= cfg_data[9:0];
				REG_SKEW:     skew_q     <= cfg_data[7:0];
			endcase
		end
	end

	assign cruise_eff = (cruise_q > CRUISE_MAX) ? CRUISE_MAX : cruise_q;

	// drive tick: skew check and corrected left speed
	assign new_diff = diff_q + {{15{cdiff_s1[16]}}, cdiff_s1};
	assign neg_diff = 32'd0 - new_diff;
	assign skew_bad = new_diff[31] ? (neg_diff > {24'd0, skew_q})
	                               : (new_diff > {24'd0, skew_q});
	// only used when the difference is within the limit, so nine bits hold it
	assign d9      = new_diff[8:0];
	assign d3      = {d9[8], d9, 1'b0} + {{2{d9[8]}}, d9};
	// truncate towards zero
	assign half_d3 = 10'((d3 + {10'd0, d3[10]}) >>> 1);
	assign sp_raw  = $signed({5'd0, cruise_eff}) - {half_d3[9], half_d3};
	assign sp      = sp_raw[10] ? 7'd0 :
	                 (sp_raw > $signed({4'd0, SPEED_MAX})) ? SPEED_MAX : sp_raw[6:0];
	assign goal_met = goal_q[15] || (trav_s1 >= {9'd0, goal_q[14:0]});
	assign blocked  = !front_s1[10] && (front_s1[9:0] < obstacle_q);

	// rotate tick: saturating sum of absolute heading changes
	assign hdiff    = {head_s1[31], head_s1} - {prior_q[31], prior_q};
	assign habs     = hdiff[32] ? 32'(33'd0 - hdiff) : hdiff[31:0];
	assign tsum     = {1'b0, turned_q} + {1'b0, habs};
	assign tsat     = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
	assign gabs     = goal_q[15] ? 16'(17'd0 - {goal_q[15], goal_q}) : goal_q;
	assign rot_done = tsat >= {12'd0, gabs, 4'd0};

	assign k_inc = {1'b0, k_q} + 7'd1;

	always_comb begin
		n_res = 7'd0;
		res   = '{left: 8'sd0, right: 8'sd0, ev: EV_AT_GOAL};
		unique case (mode_s1)
			MODE_DRIVE: begin
				n_res = {cruise_eff, 1'b0};
				res   = '{left: $signed({3'd0, k_q[5:1]} + 8'd1),
				          right: $signed({2'd0, k_inc[6:1]}), ev: EV_SPEED};
			end
			MODE_ROTATE: begin
				n_res = 7'd1;
				if (target_s1 == 16'sd0) begin
					res = '{left: 8'sd0, right: 8'sd0, ev: EV_AT_GOAL};
				end else if (!target_s1[15]) begin
					res = '{left: $signed({1'b0, turn_q}),
					        right: $signed(8'd0 - {1'b0, turn_q}), ev: EV_SPEED};
				end else begin
					res = '{left: $signed(8'd0 - {1'b0, turn_q}),
					        right: $signed({1'b0, turn_q}), ev: EV_SPEED};
				end
			end
			MODE_TICK: begin
				if (phase_q == PH_DRIVE) begin
					if (skew_bad) begin
						n_res = 7'd0;
					end else if (goal_met) begin
						n_res = 7'd1;
					end else begin
						n_res = blocked ? 7'd2 : 7'd1;
						if (k_q == 6'd0) begin
							res = '{left: $signed({1'b0, sp}),
							        right: $signed({2'd0, cruise_eff}), ev: EV_SPEED};
						end else begin
							res = '{left: 8'sd0, right: 8'sd0, ev: EV_OBSTACLE};
						end
					end
				end else if (phase_q == PH_ROTATE) begin
					n_res = rot_done ? 7'd1 : 7'd0;
				end
			end
			default: n_res = 7'd0;
		endcase
	end

	assign is_last  = (k_inc == n_res);
	assign out_load = !out_valid_q || !out_stall;
	assign emit     = valid_s1 && (n_res != 7'd0) && out_load;
	assign done     = valid_s1 && ((n_res == 7'd0) || (out_load && is_last));
	assign in_stall = valid_s1 && !done;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the input stage; the encoder deltas collapse to their difference here
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1   <= mode;
			target_s1 <= target;
			cdiff_s1  <= {left_count_delta[15], left_count_delta}
			           - {right_count_delta[15], right_count_delta};
			trav_s1   <= travelled;
			front_s1  <= front_range;
			head_s1   <= heading_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= 6'd0;
			phase_q  <= PH_IDLE;
			diff_q   <= 32'd0;
			goal_q   <= 16'sd0;
			prior_q  <= 32'sd0;
			turned_q <= 32'd0;
		end else begin
			if (done) begin
				k_q <= 6'd0;
			end else if (emit) begin
				k_q <= k_inc[5:0];
			end
			// commit the item's state change when it is done, with its final result if it has one
			if (done) begin
				unique case (mode_s1)
					MODE_DRIVE: begin
						diff_q  <= 32'd0;
						goal_q  <= target_s1;
						phase_q <= PH_DRIVE;
					end
					MODE_ROTATE: begin
						goal_q   <= target_s1;
						turned_q <= 32'd0;
						prior_q  <= head_s1;
						phase_q  <= (target_s1 == 16'sd0) ? PH_IDLE : PH_ROTATE;
					end
					MODE_TICK: begin
						if (phase_q == PH_DRIVE) begin
							diff_q <= new_diff;
							if (!skew_bad && (goal_met || blocked)) begin
								phase_q <= PH_IDLE;
							end
						end else if (phase_q == PH_ROTATE) begin
							turned_q <= tsat;
							prior_q  <= head_s1;
							if (rot_done) begin
								phase_q <= PH_IDLE;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q  <= res;
			last_q <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_speed  = res_q.left;
	assign right_speed = res_q.right;
	assign event_res   = res_q.ev;
	assign last        = last_q;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the differential drive motion controller.
module tb_top;
	import ddmc_pkg::*;

	localparam int      HOLD_CYCLES = 200;
	localparam int      RANDOM_ITEMS = 300;
	localparam longint  TURN_CAP = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic signed [7:0]   left;
		logic signed [7:0]   right;
		logic [EVENT_W-1:0]  ev;
		logic                last;
	} speed_cmd_t;

	// Tracks controller state and holds the speed commands still owed by the block.
	class motion_checker;
		logic [5:0]         cruise;
		logic [6:0]         turn_spd;
		logic [9:0]         obst;
		logic [7:0]         skew;
		logic [PHASE_W-1:0] phase;
		logic [31:0]        lsum;
		logic [31:0]        rsum;
		logic [15:0]        goal;
		logic [31:0]        prior_hdg;
		logic [31:0]        turned;
		speed_cmd_t         due[$];
		int                 mismatches;
		int                 checked;

		function new();
			cruise = 6'd30;
			turn_spd = 7'd10;
			obst = 10'd50;
			skew = 8'd10;
			phase = PH_IDLE;
			lsum = '0;
			rsum = '0;
			goal = '0;
			prior_hdg = '0;
			turned = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_CRUISE:   cruise = val[5:0];
				REG_TURN:     turn_spd = val[6:0];
				REG_OBSTACLE: obst = val[9:0];
				REG_SKEW:     skew = val[7:0];
				default: ;
			endcase
		endfunction

		function void push_cmd(longint l, longint r, logic [EVENT_W-1:0] ev);
			speed_cmd_t c;
			c.left = l[7:0];
			c.right = r[7:0];
			c.ev = ev;
			c.last = 1'b0;
			due.push_back(c);
		endfunction

		function void take_command(logic [MODE_W-1:0] m, logic signed [15:0] tgt,
				logic signed [15:0] ldc, logic signed [15:0] rdc, logic [23:0] trav,
				logic signed [10:0] fr, logic signed [31:0] hd);
			int     base;
			longint ce, ts, d, sp, g, dd, acc, f;
			base = due.size();
			ce = (cruise > CRUISE_MAX) ? 32 : longint'(cruise);
			ts = longint'(turn_spd);
			case (m)
				MODE_DRIVE: begin
					lsum = '0;
					rsum = '0;
					goal = tgt;
					phase = PH_DRIVE;
					// left and right take turns rising by one
					for (int i = 0; i < 2 * ce; i++)
						push_cmd(longint'((i + 2) / 2), longint'((i + 1) / 2), EV_SPEED);
				end
				MODE_ROTATE: begin
					goal = tgt;
					turned = '0;
					prior_hdg = hd;
					if (tgt == 0) begin
						phase = PH_IDLE;
						push_cmd(0, 0, EV_AT_GOAL);
					end else begin
						phase = PH_ROTATE;
						if (tgt > 0)
							push_cmd(ts, -ts, EV_SPEED);
						else
							push_cmd(-ts, ts, EV_SPEED);
					end
				end
				MODE_TICK: begin
					if (phase == PH_DRIVE) begin
						lsum = lsum + {{16{ldc[15]}}, ldc};
						rsum = rsum + {{16{rdc[15]}}, rdc};
						d = longint'($signed(lsum - rsum));
						// drop the tick when the wheels disagree too much
						if (d <= longint'(skew) && d >= -longint'(skew)) begin
							g = longint'($signed(goal));
							if (longint'(trav) >= g) begin
								phase = PH_IDLE;
								push_cmd(0, 0, EV_AT_GOAL);
							end else begin
								sp = ce - (3 * d) / 2;
								if (sp < 0)
									sp = 0;
								if (sp > 127)
									sp = 127;
								push_cmd(sp, ce, EV_SPEED);
								f = longint'(fr);
								if (f >= 0 && f < longint'(obst)) begin
									phase = PH_IDLE;
									push_cmd(0, 0, EV_OBSTACLE);
								end
							end
						end
					end else if (phase == PH_ROTATE) begin
						dd = longint'(hd) - longint'($signed(prior_hdg));
						if (dd < 0)
							dd = -dd;
						g = longint'($signed(goal));
						if (g < 0)
							g = -g;
						acc = longint'(turned) + dd;
						if (acc > TURN_CAP)
							acc = TURN_CAP;
						turned = acc[31:0];
						prior_hdg = hd;
						if (acc >= 16 * g) begin
							phase = PH_IDLE;
							push_cmd(0, 0, EV_AT_GOAL);
						end
					end
				end
				default: ;
			endcase
			if (due.size() > base)
				due[due.size() - 1].last = 1'b1;
		endfunction

		function void check_result(logic signed [7:0] l, logic signed [7:0] r,
				logic [EVENT_W-1:0] ev, logic lst);
			speed_cmd_t want;
			checked++;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected speed command L=%0d R=%0d ev=%0d last=%0b",
						l, r, ev, lst);
				return;
			end
			want = due.pop_front();
			if (want.left !== l || want.right !== r || want.ev !== ev || want.last !== lst) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("speed command mismatch: expected L=%0d R=%0d ev=%0d last=%0b,",
						want.left, want.right, want.ev, want.last);
					$display(" got L=%0d R=%0d ev=%0d last=%0b", l, r, ev, lst);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [MODE_W-1:0]      mode;
	logic signed [15:0]     target;
	logic signed [15:0]     left_count_delta;
	logic signed [15:0]     right_count_delta;
	logic [23:0]            travelled;
	logic signed [10:0]     front_range;
	logic signed [31:0]     heading_total;
	logic                   out_valid;
	logic                   out_stall;
	logic signed [7:0]      left_speed;
	logic signed [7:0]      right_speed;
	logic [EVENT_W-1:0]     event_res;
	logic                   last;

	motion_checker motion = new();
	bit  steady = 1'b0;
	bit  hold_req = 1'b0;
	int  items_in = 0;
	int  run_items = 0;
	int  cfg_writes = 0;
	int  phases = 0;

	differential_drive_motion_controller DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.mode              (mode),
		.target            (target),
		.left_count_delta  (left_count_delta),
		.right_count_delta (right_count_delta),
		.travelled         (travelled),
		.front_range       (front_range),
		.heading_total     (heading_total),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.left_speed        (left_speed),
		.right_speed       (right_speed),
		.event_res         (event_res),
		.last              (last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			motion.check_result(left_speed, right_speed, event_res, last);
	end

	// Result side: before each result, stall a random number of cycles (none when steady), or HOLD_CYCLES on request.
	initial begin : result_sink
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				n = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				n = steady ? 0 : $urandom_range(0, 7);
			end
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_item(input logic [MODE_W-1:0] m, input logic signed [15:0] tgt,
			input logic signed [15:0] ldc, input logic signed [15:0] rdc,
			input logic [23:0] trav, input logic signed [10:0] fr,
			input logic signed [31:0] hd);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode = m;
		target = tgt;
		left_count_delta = ldc;
		right_count_delta = rdc;
		travelled = trav;
		front_range = fr;
		heading_total = hd;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		motion.take_command(m, tgt, ldc, rdc, trav, fr, hd);
		items_in++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		motion.set_reg(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Hold the input until every owed speed command has come, then let the pipeline empty.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (motion.due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic drive_run();
		int tgt, l, r, jit, diff, trav, fr, n;
		tgt = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(10, 400);
		send_item(MODE_DRIVE, 16'(tgt), 16'($urandom), 16'($urandom), 24'($urandom),
			11'($urandom), $urandom);
		run_items++;
		diff = 0;
		trav = 0;
		n = 0;
		while (n < 16 && motion.phase == PH_DRIVE) begin
			l = $urandom_range(0, 45) - 5;
			// mostly keep the wheels close, now and then knock them apart
			jit = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 600) - 300
				: $urandom_range(0, 4) - 2;
			r = l + diff + jit;
			diff = diff + l - r;
			trav = trav + $urandom_range(0, 60);
			case ($urandom_range(0, 7))
				0: fr = (motion.obst == 0) ? -1 : $urandom_range(0, motion.obst - 1);
				1, 2: fr = -1 - $urandom_range(0, 1023);
				default: fr = $urandom_range(motion.obst, 1023);
			endcase
			send_item(MODE_TICK, 16'($urandom), 16'(l), 16'(r), 24'(trav), 11'(fr), $urandom);
			run_items++;
			n++;
		end
	endtask

	task automatic rotate_run();
		int deg, n;
		logic [31:0] hdg;
		deg = $urandom_range(1, 40);
		if ($urandom_range(0, 1))
			deg = -deg;
		if ($urandom_range(0, 15) == 0)
			deg = $urandom_range(0, 65535) - 32768;
		hdg = $urandom;
		send_item(MODE_ROTATE, 16'(deg), 16'($urandom), 16'($urandom), 24'($urandom),
			11'($urandom), hdg);
		run_items++;
		n = 0;
		while (n < 24 && motion.phase == PH_ROTATE) begin
			if ($urandom_range(0, 19) == 0)
				hdg = $urandom;
			else
				hdg = hdg + $urandom_range(0, 160) - 40;
			send_item(MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
				11'($urandom), hdg);
			run_items++;
			n++;
		end
	endtask

	task automatic random_phase(input int k);
		int stop_at;
		settle();
		phases++;
		steady = (k % 3 == 2) || (k == 1);
		write_reg(REG_CRUISE,
			10'((k % 3 == 0) ? $urandom_range(0, 63) : $urandom_range(1, 4)));
		write_reg(REG_TURN, 10'($urandom_range(0, 127)));
		write_reg(REG_OBSTACLE, 10'($urandom_range(0, 1023)));
		write_reg(REG_SKEW, 10'($urandom_range(0, 255)));
		// back up the result side while items keep coming
		if (k == 1)
			hold_req = 1'b1;
		stop_at = run_items + 50;
		while (run_items < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
						16'($urandom), 24'($urandom), 11'($urandom), $urandom);
					run_items++;
				end
				2, 3, 4, 5, 6: drive_run();
				default: rotate_run();
			endcase
		end
	endtask

	task automatic directed_items();
		// reset settings: ignored items, ramp, correction, skew drop, obstacle
		send_item(MODE_TICK, 0, 0, 0, 0, 0, 0);
		send_item(2'b11, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 11'h7FF, 32'hFFFF_FFFF);
		send_item(MODE_DRIVE, 100, 0, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 5, 0, 10, -1, 0);
		send_item(MODE_TICK, 0, 0, 20, 15, -1, 0);
		send_item(MODE_TICK, 0, 20, 0, 20, 10, 0);
		// rotation: zero target, normal turn, saturating turned sum
		send_item(MODE_ROTATE, 0, 0, 0, 0, 0, 0);
		send_item(MODE_ROTATE, 90, 0, 0, 0, 0, 1000);
		send_item(MODE_TICK, 0, 0, 0, 0, 0, 1720);
		send_item(MODE_TICK, 0, 0, 0, 0, 0, 1000);
		send_item(MODE_ROTATE, -32768, 0, 0, 0, 0, 32'h7FFF_FFFF);
		send_item(MODE_TICK, 0, 0, 0, 0, 0, 32'h7FFF_FFFE);
		send_item(MODE_TICK, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
		send_item(MODE_TICK, 0, 0, 0, 0, 0, 32'h8000_0000);
		// goal met at once: negative goal, then largest distance
		send_item(MODE_DRIVE, -5, 0, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 0, -1, 0);
		send_item(MODE_DRIVE, 32767, 0, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 0, 0, 24'hFF_FFFF, -1, 0);
		settle();
		write_reg(REG_CRUISE, 63);
		write_reg(REG_TURN, 127);
		write_reg(REG_OBSTACLE, 1023);
		write_reg(REG_SKEW, 255);
		send_item(MODE_DRIVE, 200, 0, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 255, 0, 1, 1023, 0);
		send_item(MODE_TICK, 0, 0, 510, 2, 1022, 0);
		send_item(MODE_ROTATE, 1, 0, 0, 0, 0, 0);
		settle();
		write_reg(REG_CRUISE, 0);
		write_reg(REG_TURN, 0);
		write_reg(REG_OBSTACLE, 0);
		write_reg(REG_SKEW, 0);
		send_item(MODE_DRIVE, 10, 0, 0, 0, 0, 0);
		send_item(MODE_TICK, 0, 1, 0, 0, -1, 0);
		send_item(MODE_TICK, 0, -1, 0, 5, 0, 0);
		send_item(MODE_ROTATE, -1, 0, 0, 0, 0, 0);
	endtask

	initial begin : stimulus
		int k;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_DRIVE;
		target = '0;
		left_count_delta = '0;
		right_count_delta = '0;
		travelled = '0;
		front_range = '0;
		heading_total = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		directed_items();
		k = 0;
		while (run_items < RANDOM_ITEMS) begin
			random_phase(k);
			k++;
		end
		settle();
		repeat (20) @(posedge clk);
		$display("Ran %0d transactions over %0d random settings and %0d register writes;",
			items_in, phases, cfg_writes);
		$display("checked %0d speed commands, %0d mismatched, %0d never arrived.",
			motion.checked, motion.mismatches, motion.due.size());
		if (motion.mismatches == 0 && motion.due.size() == 0)
			$display("differential_drive_motion_controller test passed");
		else
			$display("differential_drive_motion_controller test failed");
		$finish;
	end

	initial begin : watchdog
		#1600000;
		$display("differential_drive_motion_controller test failed");
		$finish;
	end

endmodule
